FILE: design/tasr_pkg.sv
// Shared types, constants and pixel scaling for the touch converter poller.
// No dependencies; used by touch_adc_spi_reader_top.
`default_nettype none

package tasr_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CMD  = 3'd1,
        PH_WAIT = 3'd2,
        PH_BUSY = 3'd3,
        PH_READ = 3'd4,
        PH_GAP  = 3'd5
    } t_phase;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_X_OFFSET      = 3'd0,
        CFG_Y_OFFSET      = 3'd1,
        CFG_X_GAIN        = 3'd2,
        CFG_Y_GAIN        = 3'd3,
        CFG_SCREEN_WIDTH  = 3'd4,
        CFG_SCREEN_HEIGHT = 3'd5,
        CFG_WAIT_TICKS    = 3'd6
    } t_cfg_idx;

    // converter commands
    localparam logic [7:0] CMD_X = 8'hD0;
    localparam logic [7:0] CMD_Y = 8'h90;

    // register reset values
    localparam logic [11:0] RST_X_OFFSET      = 12'd155;
    localparam logic [11:0] RST_Y_OFFSET      = 12'd168;
    localparam logic [15:0] RST_X_GAIN        = 16'd4279;
    localparam logic [15:0] RST_Y_GAIN        = 16'd5569;
    localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd240;
    localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd320;
    localparam logic [7:0]  RST_WAIT_TICKS    = 8'd12;

    // size - floor((raw - off) * gain / 2^16), clamped to 0..size
    function automatic logic [11:0] to_pixel(
        input logic [11:0] raw,
        input logic [11:0] off,
        input logic [15:0] gain,
        input logic [11:0] size
    );
        logic signed [12:0] diff;
        logic signed [29:0] prod;
        logic signed [29:0] shifted;
        logic signed [13:0] quot;
        logic signed [14:0] val;
        logic [11:0]        res;
        diff    = $signed({1'b0, raw}) - $signed({1'b0, off});
        prod    = 30'(diff) * 30'($signed({1'b0, gain}));
        shifted = prod >>> 16;
        quot    = shifted[13:0];
        val     = $signed({3'b000, size}) - 15'(quot);
        if (val < 15'sd0) begin
            res = 12'd0;
        end else if (val > $signed({3'b000, size})) begin
            res = size;
        end else begin
            res = val[11:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/touch_adc_spi_reader_top.sv
// Bit-level serial poller for a resistive touch converter, with pixel scaling.
// Depends on tasr_pkg (phase and register index types, to_pixel).
`default_nettype none

// Each input transfer is one half-period tick of the serial clock and yields
// exactly one output transfer carrying the pin levels (cs_n, sck, mosi) for
// that tick plus the done/touched flags and the held raw and pixel values.
// A tick is accepted every cycle while the output register is free or being
// drained; its result is registered and appears on the output in the next cycle. The throughput
// is therefore one tick per cycle, limited only by the single output register
// and the downstream tready. A poll with the pen pressed runs the X and then
// the Y conversion (16 command ticks, wait_ticks wait ticks, 2 busy ticks,
// 32 data ticks each, one deselect tick between them); pixel values are
// computed on the final data tick with one 13x17 multiply per axis.
module touch_adc_spi_reader_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // tick input; tdata: poll[0], pen_n[1], miso[2], zero pad[7:3]
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    // tick result; tdata: cs_n[0], sck[1], mosi[2], done_res[3], touched[4],
    // x_raw[16:5], y_raw[28:17], x_pixel[40:29], y_pixel[52:41], zero pad[55:53]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // configuration registers
    logic [11:0] r_x_offset, r_y_offset, r_screen_width, r_screen_height;
    logic [15:0] r_x_gain, r_y_gain;
    logic [7:0]  r_wait_ticks;

    // sequencer state
    tasr_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_bit, n_bit;
    logic [7:0]  r_wait, n_wait;
    logic [15:0] r_shift, n_shift;
    logic        r_axis, n_axis;
    logic [11:0] r_raw_x, n_raw_x, r_raw_y, n_raw_y;
    logic [11:0] r_pix_x, n_pix_x, r_pix_y, n_pix_y;

    // output register
    logic        r_out_valid;
    logic [55:0] r_out_data;

    // per-tick combinational values
    logic        in_poll, in_pen_n, in_miso;
    logic        s_accept;
    logic        cs_n, sck, mosi, done, touched;
    logic [3:0]  h_cmd;
    logic [7:0]  cmd;
    logic [7:0]  wait_inc;
    logic [15:0] shift_in;
    tasr_pkg::t_phase eff_phase;

    assign in_poll  = s_axis_tdata[0];
    assign in_pen_n = s_axis_tdata[1];
    assign in_miso  = s_axis_tdata[2];

    // handshakes
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset      <= tasr_pkg::RST_X_OFFSET;
            r_y_offset      <= tasr_pkg::RST_Y_OFFSET;
            r_x_gain        <= tasr_pkg::RST_X_GAIN;
            r_y_gain        <= tasr_pkg::RST_Y_GAIN;
            r_screen_width  <= tasr_pkg::RST_SCREEN_WIDTH;
            r_screen_height <= tasr_pkg::RST_SCREEN_HEIGHT;
            r_wait_ticks    <= tasr_pkg::RST_WAIT_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (tasr_pkg::t_cfg_idx'(i_cfg_index))
                tasr_pkg::CFG_X_OFFSET:      r_x_offset      <= i_cfg_data[11:0];
                tasr_pkg::CFG_Y_OFFSET:      r_y_offset      <= i_cfg_data[11:0];
                tasr_pkg::CFG_X_GAIN:        r_x_gain        <= i_cfg_data;
                tasr_pkg::CFG_Y_GAIN:        r_y_gain        <= i_cfg_data;
                tasr_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[11:0];
                tasr_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[11:0];
                tasr_pkg::CFG_WAIT_TICKS:    r_wait_ticks    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // tick sequencer: start decision, then the phase's work for this tick
    always_comb begin
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_wait   = r_wait;
        n_shift  = r_shift;
        n_axis   = r_axis;
        n_raw_x  = r_raw_x;
        n_raw_y  = r_raw_y;
        n_pix_x  = r_pix_x;
        n_pix_y  = r_pix_y;
        cs_n     = 1'b1;
        sck      = 1'b0;
        mosi     = 1'b0;
        done     = 1'b0;
        touched  = 1'b0;
        h_cmd    = r_bit[3:0];
        cmd      = r_axis ? tasr_pkg::CMD_Y : tasr_pkg::CMD_X;
        wait_inc = r_wait + 8'd1;
        shift_in = {r_shift[14:0], in_miso};
        eff_phase = r_phase;

        // idle (and any unused code): a poll either starts or finishes at once
        unique case (r_phase)
            tasr_pkg::PH_CMD, tasr_pkg::PH_WAIT, tasr_pkg::PH_BUSY,
            tasr_pkg::PH_READ, tasr_pkg::PH_GAP: begin
            end
            default: begin
                eff_phase = tasr_pkg::PH_IDLE;
                n_phase   = tasr_pkg::PH_IDLE;
                if (in_poll) begin
                    if (in_pen_n) begin
                        done = 1'b1;
                    end else begin
                        eff_phase = tasr_pkg::PH_CMD;
                        h_cmd     = 4'd0;
                        cmd       = tasr_pkg::CMD_X;
                        n_axis    = 1'b0;
                        n_shift   = 16'd0;
                    end
                end
            end
        endcase

        unique case (eff_phase)
            // command byte, one bit per low/high tick pair
            tasr_pkg::PH_CMD: begin
                cs_n    = 1'b0;
                sck     = h_cmd[0];
                mosi    = cmd[3'd7 - h_cmd[3:1]];
                n_phase = tasr_pkg::PH_CMD;
                n_bit   = {1'b0, h_cmd} + 5'd1;
                if (h_cmd == 4'd15) begin
                    n_bit   = 5'd0;
                    n_wait  = 8'd0;
                    n_phase = (r_wait_ticks != 8'd0) ? tasr_pkg::PH_WAIT
                                                     : tasr_pkg::PH_BUSY;
                end
            end
            // conversion wait with sck low
            tasr_pkg::PH_WAIT: begin
                cs_n   = 1'b0;
                n_wait = wait_inc;
                if (wait_inc >= r_wait_ticks) begin
                    n_phase = tasr_pkg::PH_BUSY;
                    n_bit   = 5'd0;
                end
            end
            // busy bit, ignored
            tasr_pkg::PH_BUSY: begin
                cs_n = 1'b0;
                sck  = r_bit[0];
                if (r_bit[0]) begin
                    n_phase = tasr_pkg::PH_READ;
                    n_bit   = 5'd0;
                    n_shift = 16'd0;
                end else begin
                    n_bit = 5'd1;
                end
            end
            // 16 data bits, sampled on high ticks
            tasr_pkg::PH_READ: begin
                cs_n  = 1'b0;
                sck   = r_bit[0];
                if (r_bit[0]) begin
                    n_shift = shift_in;
                end
                n_bit = r_bit + 5'd1;
                if (r_bit == 5'd31) begin
                    n_bit = 5'd0;
                    if (!r_axis) begin
                        n_raw_x = shift_in[15:4];
                        n_axis  = 1'b1;
                        n_phase = tasr_pkg::PH_GAP;
                    end else begin
                        n_raw_y = shift_in[15:4];
                        n_pix_x = tasr_pkg::to_pixel(r_raw_x, r_x_offset, r_x_gain,
                                                     r_screen_width);
                        n_pix_y = tasr_pkg::to_pixel(shift_in[15:4], r_y_offset,
                                                     r_y_gain, r_screen_height);
                        n_axis  = 1'b0;
                        n_phase = tasr_pkg::PH_IDLE;
                        done    = 1'b1;
                        touched = 1'b1;
                    end
                end
            end
            // deselect tick between the two conversions
            tasr_pkg::PH_GAP: begin
                n_phase = tasr_pkg::PH_CMD;
                n_bit   = 5'd0;
            end
            default: begin
            end
        endcase
    end

    // state update on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tasr_pkg::PH_IDLE;
            r_bit   <= 5'd0;
            r_wait  <= 8'd0;
            r_shift <= 16'd0;
            r_axis  <= 1'b0;
            r_raw_x <= 12'd0;
            r_raw_y <= 12'd0;
            r_pix_x <= 12'd0;
            r_pix_y <= 12'd0;
        end else if (s_accept) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_wait  <= n_wait;
            r_shift <= n_shift;
            r_axis  <= n_axis;
            r_raw_x <= n_raw_x;
            r_raw_y <= n_raw_y;
            r_pix_x <= n_pix_x;
            r_pix_y <= n_pix_y;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out_data <= {3'b000, n_pix_y, n_pix_x, n_raw_y, n_raw_x,
                           touched, done, mosi, sck, cs_n};
        end
    end

    // a touched result always comes with done
    a_touched_has_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
        else $error("touched without done");

    // the command phase counts only 16 ticks
    a_cmd_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == tasr_pkg::PH_CMD |-> !r_bit[4])
        else $error("command tick counter out of range");

    // the last Y data tick returns the sequencer to idle
    a_y_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && r_phase == tasr_pkg::PH_READ && r_bit == 5'd31 && r_axis
        |=> r_phase == tasr_pkg::PH_IDLE)
        else $error("sequencer not idle after Y conversion");

endmodule

`default_nettype wire

FILE: sim/touch_adc_spi_reader_top_test.sv
// Self-checking testbench for the touch converter serial poller.
// Needs tasr_pkg and touch_adc_spi_reader_top; predicts every tick result in place.
module touch_adc_spi_reader_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // one tick result, laid out as on m_axis_tdata from bit 0 up
    typedef struct packed {
        logic [11:0] y_pixel;
        logic [11:0] x_pixel;
        logic [11:0] y_raw;
        logic [11:0] x_raw;
        logic        touched;
        logic        done;
        logic        mosi;
        logic        sck;
        logic        cs_n;
    } t_tick_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // poll, pen_n, miso, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;    // cs_n, sck, mosi, done_res, touched, x_raw, y_raw,
                                  // x_pixel, y_pixel, zero pad
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    touch_adc_spi_reader_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // poller state as the testbench sees it
    tasr_pkg::t_phase seq_phase;
    logic [4:0]  tick_cnt;
    logic [7:0]  wait_cnt;
    logic [15:0] shreg;
    logic        on_y;
    logic [11:0] raw_x, raw_y, pix_x, pix_y;
    logic [15:0] cfg_val [0:6];
    logic [15:0] cfg_next [0:6];

    t_tick_out tick_results_q [$];

    int fail_count;
    int ticks_sent, busy_ticks, reads_done, penup_polls, cfg_sets;
    int src_idle_pct, snk_idle_pct;
    int hold_req, hold_left;

    // size - floor((raw - off) * gain / 2^16), clamped to 0..size
    function automatic logic [11:0] mirror_scale(input logic [11:0] raw, input logic [11:0] off,
                                                 input logic [15:0] gain,
                                                 input logic [11:0] size);
        longint prod;
        longint steps;
        longint pix;
        prod  = (longint'(raw) - longint'(off)) * longint'(gain);
        steps = prod >>> 16;
        pix   = longint'(size) - steps;
        if (pix < 0) begin
            pix = 0;
        end
        if (pix > longint'(size)) begin
            pix = longint'(size);
        end
        return pix[11:0];
    endfunction

    function automatic void reset_poller_state();
        seq_phase = tasr_pkg::PH_IDLE;
        tick_cnt  = '0;
        wait_cnt  = '0;
        shreg     = '0;
        on_y      = 1'b0;
        raw_x     = '0;
        raw_y     = '0;
        pix_x     = '0;
        pix_y     = '0;
        cfg_val[tasr_pkg::CFG_X_OFFSET]      = 16'(tasr_pkg::RST_X_OFFSET);
        cfg_val[tasr_pkg::CFG_Y_OFFSET]      = 16'(tasr_pkg::RST_Y_OFFSET);
        cfg_val[tasr_pkg::CFG_X_GAIN]        = tasr_pkg::RST_X_GAIN;
        cfg_val[tasr_pkg::CFG_Y_GAIN]        = tasr_pkg::RST_Y_GAIN;
        cfg_val[tasr_pkg::CFG_SCREEN_WIDTH]  = 16'(tasr_pkg::RST_SCREEN_WIDTH);
        cfg_val[tasr_pkg::CFG_SCREEN_HEIGHT] = 16'(tasr_pkg::RST_SCREEN_HEIGHT);
        cfg_val[tasr_pkg::CFG_WAIT_TICKS]    = 16'(tasr_pkg::RST_WAIT_TICKS);
    endfunction

    // advance the poller by one tick and return its pin levels and holds
    function automatic t_tick_out advance_poller(input logic poll, input logic pen_n,
                                                 input logic miso);
        t_tick_out   r;
        logic [4:0]  h;
        logic [7:0]  cmd;
        logic [2:0]  cmd_bit;
        r      = '0;
        r.cs_n = 1'b1;
        if (seq_phase == tasr_pkg::PH_IDLE && poll) begin
            if (pen_n) begin
                r.done = 1'b1;
            end else begin
                seq_phase = tasr_pkg::PH_CMD;
                tick_cnt  = '0;
                on_y      = 1'b0;
                shreg     = '0;
            end
        end
        h = tick_cnt;
        case (seq_phase)
            tasr_pkg::PH_CMD: begin
                cmd     = on_y ? tasr_pkg::CMD_Y : tasr_pkg::CMD_X;
                h       = h & 5'd15;
                cmd_bit = 3'(7 - h[3:1]);
                r.cs_n  = 1'b0;
                r.sck   = h[0];
                r.mosi  = cmd[cmd_bit];
                tick_cnt = h + 5'd1;
                if (h == 5'd15) begin
                    tick_cnt  = '0;
                    wait_cnt  = '0;
                    seq_phase = (cfg_val[tasr_pkg::CFG_WAIT_TICKS][7:0] != 8'd0)
                                ? tasr_pkg::PH_WAIT : tasr_pkg::PH_BUSY;
                end
            end
            tasr_pkg::PH_WAIT: begin
                r.cs_n   = 1'b0;
                wait_cnt = wait_cnt + 8'd1;
                if (wait_cnt >= cfg_val[tasr_pkg::CFG_WAIT_TICKS][7:0]) begin
                    seq_phase = tasr_pkg::PH_BUSY;
                    tick_cnt  = '0;
                end
            end
            tasr_pkg::PH_BUSY: begin
                r.cs_n = 1'b0;
                r.sck  = h[0];
                if (h[0]) begin
                    seq_phase = tasr_pkg::PH_READ;
                    tick_cnt  = '0;
                    shreg     = '0;
                end else begin
                    tick_cnt = 5'd1;
                end
            end
            tasr_pkg::PH_READ: begin
                r.cs_n = 1'b0;
                r.sck  = h[0];
                if (h[0]) begin
                    shreg = {shreg[14:0], miso};
                end
                tick_cnt = h + 5'd1;
                if (h == 5'd31) begin
                    tick_cnt = '0;
                    if (!on_y) begin
                        raw_x     = shreg[15:4];
                        on_y      = 1'b1;
                        seq_phase = tasr_pkg::PH_GAP;
                    end else begin
                        raw_y = shreg[15:4];
                        pix_x = mirror_scale(raw_x, cfg_val[tasr_pkg::CFG_X_OFFSET][11:0],
                                             cfg_val[tasr_pkg::CFG_X_GAIN],
                                             cfg_val[tasr_pkg::CFG_SCREEN_WIDTH][11:0]);
                        pix_y = mirror_scale(raw_y, cfg_val[tasr_pkg::CFG_Y_OFFSET][11:0],
                                             cfg_val[tasr_pkg::CFG_Y_GAIN],
                                             cfg_val[tasr_pkg::CFG_SCREEN_HEIGHT][11:0]);
                        on_y      = 1'b0;
                        seq_phase = tasr_pkg::PH_IDLE;
                        r.done    = 1'b1;
                        r.touched = 1'b1;
                    end
                end
            end
            tasr_pkg::PH_GAP: begin
                seq_phase = tasr_pkg::PH_CMD;
                tick_cnt  = '0;
            end
            default: ;
        endcase
        r.x_raw   = raw_x;
        r.y_raw   = raw_y;
        r.x_pixel = pix_x;
        r.y_pixel = pix_y;
        return r;
    endfunction

    // offer one tick and record its expected result once transferred
    task automatic send_tick(input logic poll, input logic pen_n, input logic miso);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b00000, miso, pen_n, poll};
        do @(posedge i_clk); while (!s_axis_tready);
        if (seq_phase != tasr_pkg::PH_IDLE || poll) begin
            busy_ticks++;
        end
        ticks_sent++;
        tick_results_q.push_back(advance_poller(poll, pen_n, miso));
    endtask

    // stop offering and wait for every outstanding result
    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tick_results_q.size() != 0);
    endtask

    // write all registers from cfg_next while nothing is in flight
    task automatic apply_config();
        tasr_pkg::t_cfg_idx idx;
        pause_sender();
        idx = idx.first();
        for (int n = 0; n < idx.num(); n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= cfg_next[idx];
            do @(posedge i_clk); while (!o_cfg_ready);
            cfg_val[idx] = cfg_next[idx];
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    // clock ticks of a running read until the given phase or idle
    task automatic clock_read(input logic [15:0] xw, input logic [15:0] yw, input bit noisy,
                              input tasr_pkg::t_phase stop_phase);
        logic [15:0] word;
        logic        p, pn, m;
        while (seq_phase != stop_phase && seq_phase != tasr_pkg::PH_IDLE) begin
            word = on_y ? yw : xw;
            p    = noisy ? 1'($urandom_range(1)) : 1'b0;
            pn   = noisy ? 1'($urandom_range(1)) : 1'b0;
            m    = 1'($urandom_range(1));
            if (seq_phase == tasr_pkg::PH_READ && tick_cnt[0]) begin
                m = word[4'(15 - tick_cnt[4:1])];
            end
            send_tick(p, pn, m);
        end
    endtask

    task automatic run_read(input logic [15:0] xw, input logic [15:0] yw, input bit noisy);
        send_tick(1'b1, 1'b0, 1'($urandom_range(1)));
        clock_read(xw, yw, noisy, tasr_pkg::PH_IDLE);
        reads_done++;
    endtask

    function automatic logic [15:0] pick_word(input logic [11:0] off);
        int r;
        r = int'(off);
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: begin
                r = r + int'($urandom_range(600)) - 300;
                if (r < 0) r = 0;
                if (r > 4095) r = 4095;
            end
            2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: ;
        endcase
        return {12'(r), 4'($urandom_range(15))};
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(12000, 1500));
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(9))
            0: return 16'd1;
            1: return 16'd4095;
            default: return 16'($urandom_range(4095, 1));
        endcase
    endfunction

    task automatic random_config();
        cfg_next[tasr_pkg::CFG_X_OFFSET]      = 16'($urandom_range(4095));
        cfg_next[tasr_pkg::CFG_Y_OFFSET]      = 16'($urandom_range(4095));
        cfg_next[tasr_pkg::CFG_X_GAIN]        = pick_gain();
        cfg_next[tasr_pkg::CFG_Y_GAIN]        = pick_gain();
        cfg_next[tasr_pkg::CFG_SCREEN_WIDTH]  = pick_size();
        cfg_next[tasr_pkg::CFG_SCREEN_HEIGHT] = pick_size();
        case ($urandom_range(19))
            0, 1, 2: cfg_next[tasr_pkg::CFG_WAIT_TICKS] = 16'($urandom_range(40, 7));
            default: cfg_next[tasr_pkg::CFG_WAIT_TICKS] = 16'($urandom_range(6));
        endcase
        apply_config();
    endtask

    // idle levels right after reset, then two polls with the pen up
    task automatic test_idle_and_pen_up();
        repeat (4) send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b1, 1'b0);
        penup_polls += 2;
    endtask

    // reset register values, raw extremes and raw right at the offset
    task automatic test_default_scaling();
        run_read(16'hFFFF, {tasr_pkg::RST_Y_OFFSET - 12'd1, 4'hF}, 1'b0);
        run_read({tasr_pkg::RST_X_OFFSET, 4'h5}, 16'h0000, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0);
        penup_polls++;
    endtask

    // register extremes, no wait phase, zero screen size, shortest nonzero wait
    task automatic test_config_extremes();
        cfg_next[tasr_pkg::CFG_X_OFFSET]      = 16'd0;
        cfg_next[tasr_pkg::CFG_Y_OFFSET]      = 16'd4095;
        cfg_next[tasr_pkg::CFG_X_GAIN]        = 16'hFFFF;
        cfg_next[tasr_pkg::CFG_Y_GAIN]        = 16'd0;
        cfg_next[tasr_pkg::CFG_SCREEN_WIDTH]  = 16'd4095;
        cfg_next[tasr_pkg::CFG_SCREEN_HEIGHT] = 16'd1;
        cfg_next[tasr_pkg::CFG_WAIT_TICKS]    = 16'd0;
        apply_config();
        run_read(16'hFFFF, 16'h0000, 1'b1);
        run_read(16'h0010, 16'hFFFF, 1'b1);
        cfg_next[tasr_pkg::CFG_X_OFFSET]      = 16'd4095;
        cfg_next[tasr_pkg::CFG_Y_OFFSET]      = 16'd0;
        cfg_next[tasr_pkg::CFG_X_GAIN]        = 16'd0;
        cfg_next[tasr_pkg::CFG_Y_GAIN]        = 16'hFFFF;
        cfg_next[tasr_pkg::CFG_SCREEN_WIDTH]  = 16'd1;
        cfg_next[tasr_pkg::CFG_SCREEN_HEIGHT] = 16'd0;
        cfg_next[tasr_pkg::CFG_WAIT_TICKS]    = 16'd1;
        apply_config();
        run_read(16'h0000, 16'hFFFF, 1'b0);
    endtask

    // register writes land between ticks of a read in progress
    task automatic test_config_mid_read();
        logic [15:0] xw, yw;
        xw = 16'h8A37;
        yw = 16'h3C4E;
        cfg_next = cfg_val;
        cfg_next[tasr_pkg::CFG_X_OFFSET]      = 16'd200;
        cfg_next[tasr_pkg::CFG_Y_OFFSET]      = 16'd150;
        cfg_next[tasr_pkg::CFG_X_GAIN]        = 16'd4000;
        cfg_next[tasr_pkg::CFG_SCREEN_WIDTH]  = 16'd800;
        cfg_next[tasr_pkg::CFG_SCREEN_HEIGHT] = 16'd480;
        cfg_next[tasr_pkg::CFG_WAIT_TICKS]    = 16'd20;
        apply_config();
        send_tick(1'b1, 1'b0, 1'b0);
        clock_read(xw, yw, 1'b0, tasr_pkg::PH_WAIT);
        repeat (5) send_tick(1'b1, 1'b1, 1'($urandom_range(1)));
        // shorten the wait below the count already reached and change the X gain
        cfg_next[tasr_pkg::CFG_WAIT_TICKS] = 16'd3;
        cfg_next[tasr_pkg::CFG_X_GAIN]     = 16'd9000;
        apply_config();
        clock_read(xw, yw, 1'b0, tasr_pkg::PH_READ);
        cfg_next[tasr_pkg::CFG_Y_GAIN] = 16'd12345;
        apply_config();
        clock_read(xw, yw, 1'b1, tasr_pkg::PH_IDLE);
        reads_done++;
    endtask

    // receiver holds off for a long stretch while ticks keep coming
    task automatic test_back_pressure();
        int saved;
        saved        = src_idle_pct;
        src_idle_pct = 0;
        hold_req     = 80;
        run_read(pick_word(cfg_val[tasr_pkg::CFG_X_OFFSET][11:0]),
                 pick_word(cfg_val[tasr_pkg::CFG_Y_OFFSET][11:0]), 1'b1);
        src_idle_pct = saved;
    endtask

    // mostly complete reads with random content, some pen-up polls, idle noise and register sets
    task automatic test_random_traffic(input int src_pct, input int snk_pct, input int budget);
        int start;
        int pick;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        random_config();
        start = busy_ticks;
        while (busy_ticks - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                random_config();
            end else if (pick < 18) begin
                send_tick(1'b1, 1'b1, 1'($urandom_range(1)));
                penup_polls++;
            end else if (pick < 24) begin
                repeat ($urandom_range(3, 1))
                    send_tick(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                run_read(pick_word(cfg_val[tasr_pkg::CFG_X_OFFSET][11:0]),
                         pick_word(cfg_val[tasr_pkg::CFG_Y_OFFSET][11:0]),
                         1'($urandom_range(1)));
            end
        end
    endtask

    // receiver side: random stalls plus an optional long hold-off
    initial begin
        hold_req  = 0;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_req > 0) begin
                hold_left = hold_req - 1;
                hold_req  = 0;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [11:0] want,
                                   input logic [11:0] got);
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        fail_count++;
    endtask

    // compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_tick_out seen;
        t_tick_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = t_tick_out'(m_axis_tdata[52:0]);
            if (tick_results_q.size() == 0) begin
                $display("%0t ns: result transfer with no tick outstanding", $time);
                fail_count++;
            end else begin
                want = tick_results_q.pop_front();
                if (seen.cs_n !== want.cs_n)
                    report_mismatch("cs_n", 12'(want.cs_n), 12'(seen.cs_n));
                if (seen.sck !== want.sck)
                    report_mismatch("sck", 12'(want.sck), 12'(seen.sck));
                if (seen.mosi !== want.mosi)
                    report_mismatch("mosi", 12'(want.mosi), 12'(seen.mosi));
                if (seen.done !== want.done)
                    report_mismatch("done_res", 12'(want.done), 12'(seen.done));
                if (seen.touched !== want.touched)
                    report_mismatch("touched", 12'(want.touched), 12'(seen.touched));
                if (seen.x_raw !== want.x_raw)     report_mismatch("x_raw", want.x_raw, seen.x_raw);
                if (seen.y_raw !== want.y_raw)     report_mismatch("y_raw", want.y_raw, seen.y_raw);
                if (seen.x_pixel !== want.x_pixel)
                    report_mismatch("x_pixel", want.x_pixel, seen.x_pixel);
                if (seen.y_pixel !== want.y_pixel)
                    report_mismatch("y_pixel", want.y_pixel, seen.y_pixel);
                if (m_axis_tdata[55:53] !== 3'b000)
                    report_mismatch("tdata pad", 12'd0, 12'(m_axis_tdata[55:53]));
            end
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d results outstanding", tick_results_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= tasr_pkg::CFG_X_OFFSET;
        i_cfg_data    <= '0;
        fail_count  = 0;
        ticks_sent  = 0;
        busy_ticks  = 0;
        reads_done  = 0;
        penup_polls = 0;
        cfg_sets    = 0;
        src_idle_pct = 13;
        snk_idle_pct = 61;
        reset_poller_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_and_pen_up();
        test_default_scaling();
        test_config_extremes();
        test_config_mid_read();
        test_back_pressure();
        test_random_traffic(13, 61, 170);
        test_random_traffic(61, 13, 170);
        test_random_traffic(0, 0, 170);

        pause_sender();
        repeat (8) @(posedge i_clk);
        $display("covered %0d ticks: %0d full X/Y reads, %0d pen-up polls, %0d register sets",
                 ticks_sent, reads_done, penup_polls, cfg_sets);
        $display("with random stalls on both sides, a long output hold-off and mid-read writes");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
design/tasr_pkg.sv
design/touch_adc_spi_reader_top.sv
sim/touch_adc_spi_reader_top_test.sv
